[hw/rtl/page_frame_stack_allocator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the page frame stack allocator
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_STACK_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PFSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pfsa assertion failed");
`define PFSA_ASSERT_IMPL(lbl, ante, cons) \
  `PFSA_ASSERT(lbl, (ante) |-> (cons))
`define PFSA_ASSERT_NEXT(lbl, ante, cons) \
  `PFSA_ASSERT(lbl, (ante) |=> (cons))
`else
`define PFSA_ASSERT(lbl, prop)
`define PFSA_ASSERT_IMPL(lbl, ante, cons)
`define PFSA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/pfsa_pkg.sv]
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pfsa_pkg;

  localparam int FRAME_COUNT_DEF = 1024;
  localparam int FRAME_BYTES_DEF = 4096;

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 11;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int REG_W  = 2;

  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_REGION = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd3;

  localparam logic [REG_W-1:0] REG_REGION_VALID  = 2'd0;
  localparam logic [REG_W-1:0] REG_REGION_BASE   = 2'd1;
  localparam logic [REG_W-1:0] REG_REGION_LENGTH = 2'd2;

  typedef struct packed {
    logic              fill_start;
    logic              fill_step;
    logic              fill_end;
    logic              pop;
    logic              push;
    logic              load_out;
    logic              use_rd;
    logic [STAT_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic region_valid;
    logic top_zero;
    logic can_push;
    logic fill_done;
  } sts_t;

endpackage

[hw/rtl/pfsa_datapath.sv]
// ----------------------------------------------------------------------------
// pfsa_datapath
// Frame stack memory, top/limit counters, fill walker, config and result regs.
// ----------------------------------------------------------------------------
`include "page_frame_stack_allocator_core_assert.svh"

module pfsa_datapath #(
  parameter int FRAME_COUNT = pfsa_pkg::FRAME_COUNT_DEF,
  parameter int FRAME_BYTES = pfsa_pkg::FRAME_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfsa_pkg::cmd_t              cmd_i,
  output pfsa_pkg::sts_t              sts_o,
  input  logic                        cfg_we_i,
  input  logic [pfsa_pkg::REG_W-1:0]  cfg_index_i,
  input  logic [pfsa_pkg::ADDR_W-1:0] cfg_data_i,
  input  logic [pfsa_pkg::ADDR_W-1:0] free_address_i,
  output logic [pfsa_pkg::ADDR_W-1:0] alloc_address_o,
  output logic [pfsa_pkg::STAT_W-1:0] status_o,
  output logic [pfsa_pkg::CNT_W-1:0]  free_frames_o,
  output logic [pfsa_pkg::CNT_W-1:0]  total_frames_o
);

  localparam int TOP_W = $clog2(FRAME_COUNT + 1);
  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int EXT_W = pfsa_pkg::ADDR_W + 1;

  logic [pfsa_pkg::ADDR_W-1:0] mem [FRAME_COUNT];
  logic [pfsa_pkg::ADDR_W-1:0] rd_q;

  logic                        region_valid_q;
  logic [pfsa_pkg::ADDR_W-1:0] region_base_q, region_length_q;

  logic [TOP_W-1:0] top_q, top_d, limit_q, limit_d, top_dec;
  logic [TOP_W-1:0] fill_n_q, fill_n_d;
  logic [EXT_W-1:0] fill_addr_q, fill_addr_d, fill_end_q, fill_end_d, region_sum;
  logic             fill_more;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [pfsa_pkg::ADDR_W-1:0] mem_wdata;

  logic [pfsa_pkg::ADDR_W-1:0] alloc_address_q;
  logic [pfsa_pkg::STAT_W-1:0] status_q;
  logic [pfsa_pkg::CNT_W-1:0]  free_frames_q, total_frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_valid_q  <= 1'b0;
      region_base_q   <= '0;
      region_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pfsa_pkg::REG_REGION_VALID:  region_valid_q  <= cfg_data_i[0];
        pfsa_pkg::REG_REGION_BASE:   region_base_q   <= cfg_data_i;
        pfsa_pkg::REG_REGION_LENGTH: region_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign top_dec    = top_q - TOP_W'(1);
  assign region_sum = {1'b0, region_base_q} + {1'b0, region_length_q};
  assign fill_more  = (fill_n_q < TOP_W'(FRAME_COUNT)) && (fill_addr_q < fill_end_q);

  always_comb begin
    fill_n_d    = fill_n_q;
    fill_addr_d = fill_addr_q;
    fill_end_d  = fill_end_q;
    if (cmd_i.fill_start) begin
      fill_n_d    = '0;
      fill_addr_d = {1'b0, region_base_q};
      fill_end_d  = region_sum[pfsa_pkg::ADDR_W] ? {1'b1, {pfsa_pkg::ADDR_W{1'b0}}}
                                                  : region_sum;
    end else if (cmd_i.fill_step && fill_more) begin
      fill_n_d    = fill_n_q + TOP_W'(1);
      fill_addr_d = fill_addr_q + EXT_W'(FRAME_BYTES);
    end
  end

  always_comb begin
    top_d   = top_q;
    limit_d = limit_q;
    if (cmd_i.fill_end) begin
      top_d   = fill_n_q;
      limit_d = fill_n_q;
    end else if (cmd_i.pop) begin
      top_d = top_dec;
    end else if (cmd_i.push) begin
      top_d = top_q + TOP_W'(1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = top_q[IDX_W-1:0];
    mem_wdata = free_address_i;
    if (cmd_i.fill_step && fill_more) begin
      mem_we    = 1'b1;
      mem_waddr = fill_n_q[IDX_W-1:0];
      mem_wdata = fill_addr_q[pfsa_pkg::ADDR_W-1:0];
    end else if (cmd_i.push) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.pop) begin
      rd_q <= mem[top_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      limit_q     <= '0;
      fill_n_q    <= '0;
      fill_addr_q <= '0;
      fill_end_q  <= '0;
    end else begin
      top_q       <= top_d;
      limit_q     <= limit_d;
      fill_n_q    <= fill_n_d;
      fill_addr_q <= fill_addr_d;
      fill_end_q  <= fill_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      alloc_address_q <= cmd_i.use_rd ? rd_q : '0;
      status_q        <= cmd_i.status;
      free_frames_q   <= pfsa_pkg::CNT_W'(top_d);
      total_frames_q  <= pfsa_pkg::CNT_W'(limit_d);
    end
  end

  assign sts_o.region_valid = region_valid_q;
  assign sts_o.top_zero     = (top_q == '0);
  assign sts_o.can_push     = (top_q < limit_q);
  assign sts_o.fill_done    = !fill_more;

  assign alloc_address_o = alloc_address_q;
  assign status_o        = status_q;
  assign free_frames_o   = free_frames_q;
  assign total_frames_o  = total_frames_q;

  `PFSA_ASSERT(a_top_within_limit, top_q <= limit_q)
  `PFSA_ASSERT(a_limit_within_depth, limit_q <= TOP_W'(FRAME_COUNT))
  `PFSA_ASSERT_IMPL(a_pop_push_excl, cmd_i.pop, !cmd_i.push && !cmd_i.fill_step)

endmodule

[hw/rtl/pfsa_ctrl.sv]
// ----------------------------------------------------------------------------
// pfsa_ctrl
// Sequencer: decodes items, runs the init fill, owns the result valid flag.
// ----------------------------------------------------------------------------
`include "page_frame_stack_allocator_core_assert.svh"

module pfsa_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pfsa_pkg::MODE_W-1:0] mode_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  pfsa_pkg::sts_t              sts_i,
  output pfsa_pkg::cmd_t              cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic                        out_valid_q, out_valid_d;
  logic [pfsa_pkg::STAT_W-1:0] stat_q, stat_d;
  logic                        use_rd_q, use_rd_d;
  logic                        slot_free, accept, finish;
  logic [pfsa_pkg::STAT_W-1:0] fin_status;
  logic                        fin_use_rd;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    stat_d     = stat_q;
    use_rd_d   = use_rd_q;
    finish     = 1'b0;
    fin_status = pfsa_pkg::ST_OK;
    fin_use_rd = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            pfsa_pkg::MODE_INIT: begin
              if (sts_i.region_valid) begin
                cmd_o.fill_start = 1'b1;
                state_d          = S_FILL;
              end else begin
                finish     = 1'b1;
                fin_status = pfsa_pkg::ST_NO_REGION;
              end
            end
            pfsa_pkg::MODE_ALLOC: begin
              if (sts_i.top_zero) begin
                finish     = 1'b1;
                fin_status = pfsa_pkg::ST_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = S_RD;
              end
            end
            pfsa_pkg::MODE_FREE: begin
              finish = 1'b1;
              if (sts_i.can_push) begin
                cmd_o.push = 1'b1;
              end else begin
                fin_status = pfsa_pkg::ST_OVERFLOW;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_FILL: begin
        if (sts_i.fill_done) begin
          cmd_o.fill_end = 1'b1;
          finish         = 1'b1;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      S_RD: begin
        finish     = 1'b1;
        fin_use_rd = 1'b1;
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.status   = stat_q;
          cmd_o.use_rd   = use_rd_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (finish) begin
      if (slot_free) begin
        cmd_o.load_out = 1'b1;
        cmd_o.status   = fin_status;
        cmd_o.use_rd   = fin_use_rd;
        state_d        = S_IDLE;
      end else begin
        stat_d   = fin_status;
        use_rd_d = fin_use_rd;
        state_d  = S_LOAD;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      stat_q      <= pfsa_pkg::ST_OK;
      use_rd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      stat_q      <= stat_d;
      use_rd_q    <= use_rd_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PFSA_ASSERT_IMPL(a_no_overwrite, out_valid_q && !out_ready_i, !cmd_o.load_out)
  `PFSA_ASSERT_NEXT(a_pop_reads, cmd_o.pop, state_q == S_RD)
  `PFSA_ASSERT_NEXT(a_fill_ends, state_q == S_FILL && sts_i.fill_done, state_q != S_FILL)

endmodule

[hw/rtl/page_frame_stack_allocator_core.sv]
// ----------------------------------------------------------------------------
// page_frame_stack_allocator_core
// Stack of free page-frame addresses with init fill, allocate and free.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in       in   in_valid/ready     mode_i, free_address_i
//  out      out  out_valid/ready    alloc_address_o, status_o, free_frames_o,
//                                   total_frames_o
//  cfg      in   cfg_valid/ready    cfg_index_i, cfg_data_i (always ready)
//
//  Free and error items: the result is loaded from idle when the result register is free.
//  Allocate: pop in idle, then S_RD loads the registered read of the frame memory.
//  Init: fill start, one memory write per frame, then fill end and result load.
//  A finished result waits in the output register; no new item is taken
//  until the current one has reached it. No clearing pass after reset.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_core #(
  parameter int FRAME_COUNT = pfsa_pkg::FRAME_COUNT_DEF,
  parameter int FRAME_BYTES = pfsa_pkg::FRAME_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pfsa_pkg::MODE_W-1:0] mode_i,
  input  logic [pfsa_pkg::ADDR_W-1:0] free_address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pfsa_pkg::ADDR_W-1:0] alloc_address_o,
  output logic [pfsa_pkg::STAT_W-1:0] status_o,
  output logic [pfsa_pkg::CNT_W-1:0]  free_frames_o,
  output logic [pfsa_pkg::CNT_W-1:0]  total_frames_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pfsa_pkg::REG_W-1:0]  cfg_index_i,
  input  logic [pfsa_pkg::ADDR_W-1:0] cfg_data_i
);

  pfsa_pkg::cmd_t cmd;
  pfsa_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  pfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfsa_datapath #(
    .FRAME_COUNT (FRAME_COUNT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .free_address_i  (free_address_i),
    .alloc_address_o (alloc_address_o),
    .status_o        (status_o),
    .free_frames_o   (free_frames_o),
    .total_frames_o  (total_frames_o)
  );

endmodule
